FILE: hdl/mrs_pkg.sv
package mrs_pkg;

  // fixed field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned DIM_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

  // one slot of the row chain: row maximum and the row it belongs to
  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic [ROW_W-1:0]         idx;
  } entry_t;

  // per-cell controls
  typedef struct packed {
    logic load;
    logic first;
    logic shift;
    logic insert;
    logic win;
  } cell_ctl_t;

endpackage

FILE: hdl/mrs_cell.sv
module mrs_cell
  import mrs_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctl_t                ctl_i,
  input  logic [ROW_W-1:0]         row_id_i,
  input  logic signed [DATA_W-1:0] elem_i,
  input  entry_t                   nbr_i,
  input  entry_t                   ins_i,
  input  entry_t                   win_i,
  output entry_t                   entry_o
);

  entry_t entry_q, entry_d;

  // running max during load, then move or take a slot during sort and readout
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load) begin
      if (ctl_i.first || ($signed(entry_q.key) < $signed(elem_i))) begin
        entry_d.key = elem_i;
      end
      entry_d.idx = row_id_i;
    end else if (ctl_i.win) begin
      entry_d = win_i;
    end else if (ctl_i.insert) begin
      entry_d = ins_i;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: hdl/mrs_store.sv
module mrs_store
  import mrs_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/matrix_row_sort_by_max.sv
// Row sort of a small matrix by descending row maximum.
// Input channel (in_valid_i / in_stall_o, element_i): the matrix is loaded
// row-major, one word per cycle; in_stall_o is high while a sort or readout
// is in progress. Each cell of the row chain keeps the running maximum of
// its row while the elements go to the element store.
// After the last element the chain runs the exchange sort: one grab step per row
// plus one compare per later row, with the compared head entry circulating
// through the chain.
// Output channel (out_valid_o / out_stall_i): the sorted matrix leaves
// row-major at one word per cycle while not stalled, limited by the single
// store read port, with out_row_o and out_col_o on every word and last_o on
// the final word. After the sort ends the first word passes the store read
// register and then the output register. A stall holds the output register;
// one read stage in front of it lets the store keep one word in flight.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 is num_rows, index 1 is
// num_cols; a write restarts the load at the first element. Out of range
// values are clamped to 1..max.
// Reset sets both dimensions to their maxima, empties the output and starts
// a fresh load; the element store and row keys need no clearing.
module matrix_row_sort_by_max
  import mrs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] element_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic [ROW_W-1:0]         out_row_o,
  output logic [ROW_W-1:0]         out_col_o,
  output logic                     last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_data_i
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_GRAB = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_READ = 4'b1000
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                  input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = DIM_W'(1);
    end else if (raw > lim) begin
      res = lim;
    end
    return res;
  endfunction

  state_e                   state_q, state_d;
  logic [DIM_W-1:0]         num_rows_q, num_cols_q;
  logic [ROW_W-1:0]         row_q, row_d, col_q, col_d;
  logic [DIM_W-1:0]         n_q, n_d, cnt_q, cnt_d;
  logic [ROW_W-1:0]         rr_q, rr_d, rc_q, rc_d;
  entry_t                   head_q, head_d;
  logic                     v1_q;
  logic [ROW_W-1:0]         row1_q, col1_q;
  logic                     last1_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] value_q;
  logic [ROW_W-1:0]         out_row_q, out_col_q;
  logic                     last_q;

  logic [DIM_W-1:0]  rows_w, cols_w, rows_last;
  logic [ROW_W-1:0]  rows_m1, cols_m1;
  logic              in_acc, cfg_we, cfg_hit, adv, issue, swap;
  logic              rot_en, win_en;
  logic [DIM_W-1:0]  ins_pos;
  entry_t            ins_ent, win_ent;
  entry_t            chain [MAX_ROWS];
  cell_ctl_t         ctl [MAX_ROWS];
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] rdata;

  // dimensions in use
  assign rows_w    = clamp_dim(num_rows_q, DIM_W'(MAX_ROWS));
  assign cols_w    = clamp_dim(num_cols_q, DIM_W'(MAX_COLS));
  assign rows_last = rows_w - DIM_W'(1);
  assign rows_m1   = ROW_W'(rows_last);
  assign cols_m1   = ROW_W'(cols_w - DIM_W'(1));

  // handshakes
  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && ((cfg_index_i == REG_NUM_ROWS) ||
                                  (cfg_index_i == REG_NUM_COLS));
  assign adv         = v1_q && (!out_valid_q || !out_stall_i);

  // head loses its place only to a strictly larger key
  assign swap    = $signed(head_q.key) < $signed(chain[0].key);
  assign win_ent = swap ? chain[0] : head_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    rr_d    = rr_q;
    rc_d    = rc_q;
    head_d  = head_q;
    rot_en  = 1'b0;
    win_en  = 1'b0;
    issue   = 1'b0;
    ins_pos = rows_last;
    ins_ent = chain[0];
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (col_q == cols_m1) begin
            col_d = '0;
            if (row_q == rows_m1) begin
              row_d   = '0;
              n_d     = rows_w;
              state_d = ST_GRAB;
            end else begin
              row_d = row_q + ROW_W'(1);
            end
          end else begin
            col_d = col_q + ROW_W'(1);
          end
        end
      end
      ST_GRAB: begin
        // head of the unsorted part becomes the candidate, chain rotates
        rot_en = 1'b1;
        head_d = chain[0];
        n_d    = n_q - DIM_W'(1);
        cnt_d  = n_q - DIM_W'(1);
        if (n_q == DIM_W'(1)) begin
          rr_d    = '0;
          rc_d    = '0;
          state_d = ST_READ;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        // loser goes back to the tail of the unsorted part
        rot_en  = 1'b1;
        ins_pos = n_q - DIM_W'(1);
        ins_ent = swap ? head_q : chain[0];
        head_d  = win_ent;
        cnt_d   = cnt_q - DIM_W'(1);
        if (cnt_q == DIM_W'(1)) begin
          win_en  = 1'b1;
          state_d = ST_GRAB;
        end
      end
      ST_READ: begin
        if (!v1_q || adv) begin
          issue = 1'b1;
          if (rc_q == cols_m1) begin
            rot_en = 1'b1;
            rc_d   = '0;
            if (rr_q == rows_m1) begin
              state_d = ST_LOAD;
            end else begin
              rr_d = rr_q + ROW_W'(1);
            end
          end else begin
            rc_d = rc_q + ROW_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end
  end

  // row chain
  for (genvar j = 0; j < MAX_ROWS; j++) begin : g_cell
    entry_t nbr;
    if (j < MAX_ROWS - 1) begin : g_nbr
      assign nbr = chain[j+1];
    end else begin : g_end
      assign nbr = chain[j];
    end

    assign ctl[j].load   = in_acc && (row_q == ROW_W'(j));
    assign ctl[j].first  = (col_q == '0);
    assign ctl[j].shift  = rot_en && (DIM_W'(j) < ins_pos);
    assign ctl[j].insert = rot_en && (DIM_W'(j) == ins_pos);
    assign ctl[j].win    = win_en && (DIM_W'(j) == rows_last);

    mrs_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl[j]),
      .row_id_i (row_q),
      .elem_i   (element_i),
      .nbr_i    (nbr),
      .ins_i    (ins_ent),
      .win_i    (win_ent),
      .entry_o  (chain[j])
    );
  end

  // element store
  assign waddr = AW'(int'(row_q) * MAX_COLS + int'(col_q));
  assign raddr = AW'(int'(chain[0].idx) * MAX_COLS + int'(rc_q));

  mrs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (waddr),
    .wdata_i (element_i),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      num_rows_q  <= DIM_W'(MAX_ROWS);
      num_cols_q  <= DIM_W'(MAX_COLS);
      row_q       <= '0;
      col_q       <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      rr_q        <= '0;
      rc_q        <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      n_q     <= n_d;
      cnt_q   <= cnt_d;
      rr_q    <= rr_d;
      rc_q    <= rc_d;
      if (cfg_we && (cfg_index_i == REG_NUM_ROWS)) begin
        num_rows_q <= cfg_data_i;
      end
      if (cfg_we && (cfg_index_i == REG_NUM_COLS)) begin
        num_cols_q <= cfg_data_i;
      end
      if (issue) begin
        v1_q <= 1'b1;
      end else if (adv) begin
        v1_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // candidate, read stage sideband and output word
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    if (issue) begin
      row1_q  <= rr_q;
      col1_q  <= rc_q;
      last1_q <= (rr_q == rows_m1) && (rc_q == cols_m1);
    end
    if (adv) begin
      value_q   <= $signed(rdata);
      out_row_q <= row1_q;
      out_col_q <= col1_q;
      last_q    <= last1_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = last_q;

  // final word sits at the corner of the matrix in use
  a_last_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> ((out_row_o == rows_m1) && (out_col_o == cols_m1)))
    else $error("last word not at the matrix corner");

  // compare count stays within the unsorted part
  a_cmp_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ((cnt_q != '0) && (cnt_q <= n_q)))
    else $error("compare count out of range");

  // a grab always has an unsorted row left
  a_grab_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GRAB) |-> ((n_q != '0) && (n_q <= rows_w)))
    else $error("grab with no unsorted row");

  // a held read word is never overwritten by a new read
  a_read_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv) |=> $stable(rdata))
    else $error("read word lost while output stalled");

endmodule

FILE: tb/tb_matrix_row_sort_by_max.sv
`timescale 1ns / 100ps

module tb_matrix_row_sort_by_max;
  import mrs_pkg::*;

  localparam int unsigned MAX_ROWS       = 8;
  localparam int unsigned MAX_COLS       = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 290;

  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(3);

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
  typedef enum {VAL_FULL, VAL_TIES, VAL_EXTREME} value_mode_e;

  // one word of the sorted matrix
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic                     last;
  } sorted_word_t;

  // predicts the sorted readout and checks the output words against it
  class row_sort_scoreboard;
    logic signed [DATA_W-1:0] cells [MAX_ROWS*MAX_COLS];
    logic signed [DATA_W-1:0] row_max [MAX_ROWS];
    logic [DIM_W-1:0]         rows_reg;
    logic [DIM_W-1:0]         cols_reg;
    int unsigned              load_count;
    int unsigned              mismatches;
    sorted_word_t             sorted_words[$];

    function new();
      rows_reg   = DIM_W'(MAX_ROWS);
      cols_reg   = DIM_W'(MAX_COLS);
      load_count = 0;
      mismatches = 0;
    endfunction

    // dimension in effect for a register value
    function int unsigned span(logic [DIM_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      if (idx == REG_NUM_ROWS) rows_reg = data;
      else if (idx == REG_NUM_COLS) cols_reg = data;
      else return;
      load_count = 0;
    endfunction

    function void note_element(logic signed [DATA_W-1:0] elem);
      int unsigned      rows, cols, total, r, c, i, k;
      logic [ROW_W-1:0] order [MAX_ROWS];
      logic [ROW_W-1:0] held;
      sorted_word_t     w;
      rows  = span(rows_reg, MAX_ROWS);
      cols  = span(cols_reg, MAX_COLS);
      total = rows * cols;
      if (load_count >= total) load_count = 0;
      r = load_count / cols;
      c = load_count % cols;
      cells[r*MAX_COLS + c] = elem;
      if (c == 0 || row_max[r] < elem) row_max[r] = elem;
      if (load_count + 1 < total) begin
        load_count++;
        return;
      end
      // exchange sort of row positions, keys travel with their rows
      for (i = 0; i < MAX_ROWS; i++) order[i] = ROW_W'(i);
      for (i = 0; i < rows; i++) begin
        for (k = i + 1; k < rows; k++) begin
          if (row_max[order[i]] < row_max[order[k]]) begin
            held     = order[i];
            order[i] = order[k];
            order[k] = held;
          end
        end
      end
      // row-major readout of the reordered matrix
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) begin
          w.value = cells[order[r]*MAX_COLS + c];
          w.row   = ROW_W'(r);
          w.col   = ROW_W'(c);
          w.last  = (r + 1 == rows) && (c + 1 == cols);
          sorted_words.push_back(w);
        end
      end
      load_count = 0;
    endfunction

    function void check_word(logic signed [DATA_W-1:0] value, logic [ROW_W-1:0] row,
                             logic [ROW_W-1:0] col, logic last);
      sorted_word_t w;
      if (sorted_words.size() == 0) begin
        mismatches++;
        $display("%0t: output word with none expected (value %0d row %0d col %0d)",
                 $time, value, row, col);
        return;
      end
      w = sorted_words.pop_front();
      if (value !== w.value) begin
        mismatches++;
        $display("%0t: value expected %0d actual %0d", $time, w.value, value);
      end
      if (row !== w.row) begin
        mismatches++;
        $display("%0t: out_row expected %0d actual %0d", $time, w.row, row);
      end
      if (col !== w.col) begin
        mismatches++;
        $display("%0t: out_col expected %0d actual %0d", $time, w.col, col);
      end
      if (last !== w.last) begin
        mismatches++;
        $display("%0t: last expected %0d actual %0d", $time, w.last, last);
      end
    endfunction

    function int unsigned pending();
      return sorted_words.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] element_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] value_o;
  logic [ROW_W-1:0]         out_row_o;
  logic [ROW_W-1:0]         out_col_o;
  logic                     last_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [DIM_W-1:0]         cfg_data_i;

  row_sort_scoreboard sb = new();

  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  bit          sender_bursty = 1'b0;
  int unsigned quiet_cycles = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  int unsigned stall_left   = 0;

  matrix_row_sort_by_max #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .element_i  (element_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .last_o     (last_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stall pattern; the mode is picked anew when its random hold count runs out
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 60);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_left % 7) < 3);
    endcase
  end

  // monitor: output check, input prediction, register writes, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_word(value_o, out_row_o, out_col_o, last_o);
      if (in_valid_i && !in_stall_o) sb.note_element(element_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_element(value_mode_e m);
    case (m)
      VAL_FULL: return $urandom;
      VAL_TIES: return DATA_W'(int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // register value, weighted toward small matrices
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'($urandom_range(9, 15));
      2:       return DIM_W'(MAX_ROWS);
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // one word on the input channel, called and returning at a falling edge
  task automatic send_element(logic signed [DATA_W-1:0] v);
    if (sender_bursty && burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i = 1'b1;
    element_i  = v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // hold the input until every sorted word is out, then let the block settle
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      total;
    int unsigned      random_target;
    logic [DIM_W-1:0] rows_val;
    logic [DIM_W-1:0] cols_val;
    value_mode_e      vmode;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    element_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_NUM_ROWS;
    cfg_data_i  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero acts as one: every element is a 1x1 matrix
    write_cfg(REG_NUM_ROWS, '0);
    write_cfg(REG_NUM_COLS, '0);
    send_element(INT_MIN);
    send_element(INT_MAX);
    send_element('0);
    send_element('1);

    // oversize rows act as the maximum; single column with ties and extremes
    write_cfg(REG_NUM_ROWS, 4'hf);
    write_cfg(REG_NUM_COLS, 4'd1);
    send_element(32'sd5);
    send_element(INT_MIN);
    send_element(32'sd5);
    send_element(INT_MAX);
    send_element('1);
    send_element(INT_MIN);
    send_element('0);
    send_element(32'sd5);

    // unknown indexes mid-load leave the load running
    write_cfg(REG_NUM_ROWS, 4'd2);
    write_cfg(REG_NUM_COLS, 4'd2);
    send_element(32'sd7);
    send_element(-32'sd3);
    write_cfg(REG_UNUSED_A, 4'ha);
    write_cfg(REG_UNUSED_B, 4'h5);
    send_element(32'sd9);
    send_element(-32'sd3);

    // a real write mid-load drops the partial matrix; equal maxima stay put
    send_element(32'sd1);
    send_element(32'sd2);
    send_element(32'sd3);
    write_cfg(REG_NUM_COLS, 4'd2);
    send_element(-32'sd8);
    send_element(32'sd2);
    send_element(32'sd2);
    send_element(-32'sd8);

    // random phases of register settings and matrices
    random_target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_target) begin
      case (phase)
        0: begin
          rows_val = DIM_W'(MAX_ROWS);
          cols_val = DIM_W'(MAX_COLS);
        end
        1: begin
          rows_val = 4'd1;
          cols_val = 4'd1;
        end
        default: begin
          rows_val = pick_dim();
          cols_val = pick_dim();
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_cfg(REG_NUM_ROWS, rows_val);
        write_cfg(REG_NUM_COLS, cols_val);
      end else begin
        write_cfg(REG_NUM_COLS, cols_val);
        write_cfg(REG_NUM_ROWS, rows_val);
      end
      if ($urandom_range(0, 4) == 0)
        write_cfg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                  DIM_W'($urandom_range(0, 15)));
      total = sb.span(rows_val, MAX_ROWS) * sb.span(cols_val, MAX_COLS);
      sender_bursty = ($urandom_range(0, 3) != 0);

      // broken sequence: partial matrix cut off by a column write
      if (total > 1 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, total - 1)) send_element(rand_element(VAL_FULL));
        cols_val = pick_dim();
        write_cfg(REG_NUM_COLS, cols_val);
        total = sb.span(rows_val, MAX_ROWS) * sb.span(cols_val, MAX_COLS);
      end

      repeat ((total > 16) ? 1 : $urandom_range(1, 3)) begin
        vmode = value_mode_e'($urandom_range(0, 2));
        repeat (total) send_element(rand_element(vmode));
      end
      phase++;
    end

    // drain and a final quiet stretch to catch stray words
    wait_drained();
    repeat (40) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: matrix_row_sort_by_max.f
hdl/mrs_pkg.sv
hdl/mrs_cell.sv
hdl/mrs_store.sv
hdl/matrix_row_sort_by_max.sv
tb/tb_matrix_row_sort_by_max.sv
